@@ hw/rtl/sw_med_pkg.sv @@
// ----------------------------------------------------------------------------
// sw_med_pkg
// Shared widths, types and helpers for the sliding window median core.
// ----------------------------------------------------------------------------
package sw_med_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int OUT_W      = SAMPLE_W + 1;
	localparam int WINDOW_MAX = 64;
	localparam int IDX_W      = $clog2(WINDOW_MAX);
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
	localparam int WSIZE_W    = 7;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [OUT_W-1:0]    median_t;
	typedef logic [IDX_W-1:0]           idx_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [WSIZE_W-1:0]         wsize_t;

	// What a cell shows its neighbors in the current cycle
	typedef struct packed {
		logic    valid;
		logic    gt;
		logic    rm;
		idx_t    age;
		sample_t value;
	} cell_view_t;

	// Broadcast from the control to every cell
	typedef struct packed {
		logic    en;
		logic    clr;
		logic    start;
		logic    full;
		idx_t    age_last;
		sample_t sample;
	} cell_bcast_t;

	// Beyond the low end: always valid, never greater than the new sample
	localparam cell_view_t LEFT_EDGE = '{valid: 1'b1, gt: 1'b0, rm: 1'b0,
		age: '0, value: '0};
	// Beyond the high end: empty, so it sorts above everything
	localparam cell_view_t RIGHT_EDGE = '{valid: 1'b0, gt: 1'b1, rm: 1'b0,
		age: '0, value: '0};

	// Clamp the requested window to 1..WINDOW_MAX
	function automatic cnt_t eff_window(input wsize_t w);
		cnt_t k;
		begin
			if (w == '0) begin
				k = cnt_t'(1);
			end else if ({1'b0, w} > (WSIZE_W+1)'(WINDOW_MAX)) begin
				k = cnt_t'(WINDOW_MAX);
			end else begin
				k = cnt_t'(w);
			end
			return k;
		end
	endfunction

endpackage

@@ hw/rtl/sw_med_in_if.sv @@
// ----------------------------------------------------------------------------
// sw_med_in_if
// Sample channel: valid/ready with the sample and its start flag.
// ----------------------------------------------------------------------------
interface sw_med_in_if;
	logic               valid;
	logic               ready;
	sw_med_pkg::sample_t sample;
	logic               start_req;

	modport source (output valid, output sample, output start_req, input ready);
	modport sink (input valid, input sample, input start_req, output ready);
endinterface

@@ hw/rtl/sw_med_out_if.sv @@
// ----------------------------------------------------------------------------
// sw_med_out_if
// Result channel: valid/ready with twice the window median.
// ----------------------------------------------------------------------------
interface sw_med_out_if;
	logic               valid;
	logic               ready;
	sw_med_pkg::median_t median_doubled;

	modport source (output valid, output median_doubled, input ready);
	modport sink (input valid, input median_doubled, output ready);
endinterface

@@ hw/rtl/sw_med_cfg_if.sv @@
// ----------------------------------------------------------------------------
// sw_med_cfg_if
// Configuration write channel carrying the window size.
// ----------------------------------------------------------------------------
interface sw_med_cfg_if;
	logic              valid;
	logic              ready;
	sw_med_pkg::wsize_t window_size;

	modport source (output valid, output window_size, input ready);
	modport sink (input valid, input window_size, output ready);
endinterface

@@ hw/rtl/sliding_window_median_core.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median_core
// Running median over the last window_size signed samples.
// ----------------------------------------------------------------------------
// Takes one sample per clock, back to back, for as long as results are taken.
// The window lives in a row of 64 cells kept in ascending order; each cell
// also holds the age of its sample, so in a full window the oldest entry
// drops out on every item and the new sample slides into place in the same
// cycle, every cell looking only at itself and its two neighbors. Once the
// window holds window_size samples, each item yields one result, twice the
// median (the sum of the two middle values, or the middle value doubled for
// odd sizes). After its item is accepted, a result passes the middle-select
// stage, which picks the middle entries out of the row, and then the output
// register, which adds them. A full output only stalls the input once the
// two stages behind it are full too. window_size 0 acts as 1, sizes above
// 64 act as 64. Writing window_size or sending an item with start_req set
// empties the window; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sliding_window_median_core (
	input  logic         clk,
	input  logic         arst_n,
	sw_med_in_if.sink    samples,
	sw_med_out_if.source medians,
	sw_med_cfg_if.sink   cfg
);

	localparam int NCELL = sw_med_pkg::WINDOW_MAX;

	// Window setup, taken from the last configuration write
	sw_med_pkg::cnt_t    k_q;
	sw_med_pkg::idx_t    age_last_q;
	sw_med_pkg::idx_t    lo_idx_q;
	sw_med_pkg::idx_t    hi_idx_q;
	sw_med_pkg::cnt_t    k_cfg;

	// Fill level and pending result
	sw_med_pkg::cnt_t    fill_q;
	sw_med_pkg::cnt_t    fill_eff;
	sw_med_pkg::cnt_t    fill_nx;
	logic                full;
	logic                due_q;

	// Middle-select stage and output register
	logic                v_s2;
	sw_med_pkg::sample_t lo_s2;
	sw_med_pkg::sample_t hi_s2;
	logic                out_v_q;
	sw_med_pkg::median_t med_q;

	logic                out_en;
	logic                s2_en;
	logic                take;
	logic                cfg_wr;

	sw_med_pkg::cell_bcast_t bc;
	sw_med_pkg::cell_view_t  view [NCELL];
	logic [NCELL:0]          pr;
	logic [NCELL-1:0]        vld_vec;

	// Stage enables: each stage advances when the one after it can take it
	assign out_en        = ~out_v_q | medians.ready;
	assign s2_en         = ~v_s2 | out_en;
	assign samples.ready = ~due_q | s2_en;
	assign take          = samples.valid & samples.ready;
	assign cfg.ready     = 1'b1;
	assign cfg_wr        = cfg.valid;

	// A start flag drops the current fill before this sample goes in
	assign fill_eff = samples.start_req ? '0 : fill_q;
	assign full     = (fill_eff == k_q);
	assign fill_nx  = full ? fill_eff : fill_eff + sw_med_pkg::cnt_t'(1);
	assign k_cfg    = sw_med_pkg::eff_window(cfg.window_size);

	always_comb begin
		bc.en       = take;
		bc.clr      = cfg_wr;
		bc.start    = samples.start_req;
		bc.full     = full;
		bc.age_last = age_last_q;
		bc.sample   = samples.sample;
	end

	// Row of sorted cells; removal position ripples up through pr
	assign pr[0] = 1'b0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		sw_med_pkg::cell_view_t left_v;
		sw_med_pkg::cell_view_t right_v;

		if (i == 0) begin : g_lo
			assign left_v = sw_med_pkg::LEFT_EDGE;
		end else begin : g_lo_n
			assign left_v = view[i-1];
		end
		if (i == NCELL - 1) begin : g_hi
			assign right_v = sw_med_pkg::RIGHT_EDGE;
		end else begin : g_hi_n
			assign right_v = view[i+1];
		end

		sw_med_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.bc     (bc),
			.left   (left_v),
			.right  (right_v),
			.pr_in  (pr[i]),
			.pr_out (pr[i+1]),
			.view   (view[i])
		);

		assign vld_vec[i] = view[i].valid;
	end

	// Hold the window setup; a write also empties the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= sw_med_pkg::cnt_t'(1);
			age_last_q <= '0;
			lo_idx_q   <= '0;
			hi_idx_q   <= '0;
		end else if (cfg_wr) begin
			k_q        <= k_cfg;
			age_last_q <= sw_med_pkg::idx_t'(k_cfg - sw_med_pkg::cnt_t'(1));
			hi_idx_q   <= sw_med_pkg::idx_t'(k_cfg >> 1);
			if (k_cfg[0]) begin
				lo_idx_q <= sw_med_pkg::idx_t'(k_cfg >> 1);
			end else begin
				lo_idx_q <= sw_med_pkg::idx_t'((k_cfg >> 1) - sw_med_pkg::cnt_t'(1));
			end
		end
	end

	// Track the fill level and flag a result once the window is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			due_q  <= 1'b0;
		end else if (cfg_wr) begin
			fill_q <= '0;
			due_q  <= 1'b0;
		end else begin
			if (take) begin
				fill_q <= fill_nx;
				due_q  <= (fill_nx == k_q);
			end else if (s2_en) begin
				due_q <= 1'b0;
			end
		end
	end

	// Pick the two middle entries out of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_en) begin
			v_s2 <= due_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && due_q) begin
			lo_s2 <= view[lo_idx_q].value;
			hi_s2 <= view[hi_idx_q].value;
		end
	end

	// Add them into the output register; hold while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_en) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && v_s2) begin
			med_q <= sw_med_pkg::median_t'(lo_s2) + sw_med_pkg::median_t'(hi_s2);
		end
	end

	assign medians.valid          = out_v_q;
	assign medians.median_doubled = med_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------

	// The window never holds more samples than its size
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= k_q)
		else $error("fill level above window size");

	// Cell valid bits agree with the fill level
	assert property (@(posedge clk) disable iff (!arst_n)
		!samples.start_req |-> ($countones(vld_vec) == 32'(fill_q)))
		else $error("cell occupancy differs from fill level");

	// When the window is full, at least one cell holds the oldest sample
	assert property (@(posedge clk) disable iff (!arst_n)
		(!samples.start_req && fill_q == k_q) |-> pr[NCELL])
		else $error("no oldest entry found in a full window");

	// A pending result is never overwritten while its stage is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		(due_q && !s2_en && !cfg_wr) |=> due_q)
		else $error("pending result lost");

endmodule

@@ hw/rtl/sw_med_cell.sv @@
// ----------------------------------------------------------------------------
// sw_med_cell
// One slot of the sorted window: value, age and valid bit. Updates from its
// own content and its two neighbors when an item is taken; a configuration write clears it.
// ----------------------------------------------------------------------------
module sw_med_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sw_med_pkg::cell_bcast_t bc,
	input  sw_med_pkg::cell_view_t  left,
	input  sw_med_pkg::cell_view_t  right,
	input  logic                    pr_in,
	output logic                    pr_out,
	output sw_med_pkg::cell_view_t  view
);

	logic                   valid_q;
	sw_med_pkg::idx_t       age_q;
	sw_med_pkg::sample_t    value_q;
	sw_med_pkg::cell_view_t m_here;
	sw_med_pkg::cell_view_t m_below;
	logic                   valid_nx;
	sw_med_pkg::idx_t       age_nx;
	sw_med_pkg::sample_t    value_nx;

	// A start flag empties the window before this item goes in
	always_comb begin
		view.valid = valid_q & ~bc.start;
		view.value = value_q;
		view.age   = age_q;
		view.gt    = ~view.valid | ($signed(value_q) > $signed(bc.sample));
		view.rm    = bc.full & view.valid & (age_q == bc.age_last);
	end

	assign pr_out = pr_in | view.rm;

	// Close the gap left by the oldest entry, then open one for the new sample
	always_comb begin
		m_here  = pr_out ? right : view;
		m_below = pr_in ? view : left;
		valid_nx = m_here.valid | m_below.valid;
		if (!m_here.gt) begin
			value_nx = m_here.value;
			age_nx   = m_here.age + sw_med_pkg::idx_t'(1);
		end else if (m_below.gt) begin
			value_nx = m_below.value;
			age_nx   = m_below.age + sw_med_pkg::idx_t'(1);
		end else begin
			value_nx = bc.sample;
			age_nx   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (bc.clr) begin
			valid_q <= 1'b0;
		end else if (bc.en) begin
			valid_q <= valid_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (bc.en) begin
			value_q <= value_nx;
			age_q   <= age_nx;
		end
	end

endmodule
